// ----- rtl/core/mfdi_pkg.sv -----
// Shared constants and the rule table of the fuzzy depth inference block.
package mfdi_pkg;

  localparam int IO_FRAC = 12;
  localparam int IN_W    = 16;
  localparam int DEPTH_W = 14;

  localparam logic [IN_W-1:0] ENT_HI  = 16'd24576;
  localparam logic [IN_W-1:0] UNIT_HI = 16'd4096;

  localparam logic [DEPTH_W-1:0] DEPTH_DEFAULT = 14'd8192;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN     = 14'd4096;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX     = 14'd12288;

  typedef enum logic [1:0] {
    DEP_SHALLOW  = 2'd0,
    DEP_MODERATE = 2'd1,
    DEP_DEEP     = 2'd2
  } depth_class_t;

  // Rule consequent, indexed by entropy*9 + edge*3 + pressure set.
  localparam depth_class_t RULE_CLASS [27] = '{
    DEP_SHALLOW,  DEP_SHALLOW,  DEP_MODERATE,
    DEP_SHALLOW,  DEP_MODERATE, DEP_MODERATE,
    DEP_MODERATE, DEP_MODERATE, DEP_DEEP,
    DEP_SHALLOW,  DEP_MODERATE, DEP_MODERATE,
    DEP_MODERATE, DEP_MODERATE, DEP_DEEP,
    DEP_MODERATE, DEP_DEEP,     DEP_DEEP,
    DEP_MODERATE, DEP_MODERATE, DEP_DEEP,
    DEP_MODERATE, DEP_DEEP,     DEP_DEEP,
    DEP_DEEP,     DEP_DEEP,     DEP_DEEP
  };

endpackage

// ----- rtl/core/mfdi_feature_if.sv -----
// Feature channel: one word carries the three input features.
interface mfdi_feature_if;
  logic                             valid;
  logic                             ready;
  logic signed [mfdi_pkg::IN_W-1:0] entropy_level;
  logic signed [mfdi_pkg::IN_W-1:0] edge_strength;
  logic signed [mfdi_pkg::IN_W-1:0] pressure_level;

  modport source (output valid, entropy_level, edge_strength, pressure_level, input ready);
  modport sink (input valid, entropy_level, edge_strength, pressure_level, output ready);
endinterface

// ----- rtl/core/mfdi_depth_if.sv -----
// Depth channel: one word carries the defuzzified depth and its default flag.
interface mfdi_depth_if;
  logic                            valid;
  logic                            ready;
  logic [mfdi_pkg::DEPTH_W-1:0]    depth_value;
  logic                            used_default;

  modport source (output valid, depth_value, used_default, input ready);
  modport sink (input valid, depth_value, used_default, output ready);
endinterface

// ----- rtl/core/mfdi_member.sv -----
// Three-stage trapezoid membership evaluator with reciprocal-multiply slopes.
module mfdi_member #(
  parameter int FRAC_BITS = 12,
  parameter int XW = 15,
  parameter int A = 0,
  parameter int B = 0,
  parameter int C = 0,
  parameter int D = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [XW-1:0]        x,
  output logic [FRAC_BITS:0]   memb
);
  localparam int F  = FRAC_BITS;
  localparam int K  = 3 * F + 2;
  localparam int RW = 2 * F + 5;
  localparam int PW = F + 1 + RW;
  localparam int WR = (B > A) ? B - A : 1;
  localparam int WF = (D > C) ? D - C : 1;
  // Rounded-up reciprocals; exact for every slope offset below the width.
  localparam logic [63:0] MR = ((64'd1 << K) + 64'(WR) - 64'd1) / 64'(WR);
  localparam logic [63:0] MF = ((64'd1 << K) + 64'(WF) - 64'd1) / 64'(WF);

  logic          full1, zero1, rise1;
  logic [XW-1:0] t1;
  logic          full2, zero2;
  logic [PW-1:0] prod2;

  always_ff @(posedge clk) begin
    if (en) begin
      full1 <= (x >= XW'(B)) && (x <= XW'(C));
      zero1 <= (x <= XW'(A)) || (x >= XW'(D));
      rise1 <= x < XW'(B);
      t1    <= (x < XW'(B)) ? x - XW'(A) : XW'(D) - x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full2 <= full1;
      zero2 <= zero1;
      prod2 <= PW'(t1[F:0]) * PW'(rise1 ? MR[RW-1:0] : MF[RW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (full2) begin
        memb <= {1'b1, F'(0)};
      end else if (zero2) begin
        memb <= '0;
      end else begin
        memb <= prod2[K-F +: F+1];
      end
    end
  end
endmodule

// ----- rtl/core/mfdi_fuzzify.sv -----
// Feature clamp, fuzzification and min/max rule evaluation (five stages).
module mfdi_fuzzify #(
  parameter int FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [mfdi_pkg::IN_W-1:0] entropy_level,
  input  logic signed [mfdi_pkg::IN_W-1:0] edge_strength,
  input  logic signed [mfdi_pkg::IN_W-1:0] pressure_level,
  output logic                             out_valid,
  output logic [2:0][FRAC_BITS:0]          strength
);
  import mfdi_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int XW  = F + 3;
  localparam int MW  = F + 1;
  localparam int SHL = (F >= IO_FRAC) ? F - IO_FRAC : 0;
  localparam int SHR = (F >= IO_FRAC) ? 0 : IO_FRAC - F;

  localparam int E15 = ((3 << F) + 1) / 2;
  localparam int E25 = ((5 << F) + 1) / 2;
  localparam int E35 = ((7 << F) + 1) / 2;
  localparam int E45 = ((9 << F) + 1) / 2;
  localparam int E30 = 3 << F;
  localparam int E60 = 6 << F;
  localparam int G20 = ((1 << F) + 2) / 5;
  localparam int G35 = ((7 << F) + 10) / 20;
  localparam int G65 = ((13 << F) + 10) / 20;
  localparam int G80 = ((4 << F) + 2) / 5;
  localparam int P25 = ((1 << F) + 2) / 4;
  localparam int P40 = ((2 << F) + 2) / 5;
  localparam int P60 = ((3 << F) + 2) / 5;
  localparam int P75 = ((3 << F) + 2) / 4;
  localparam int ONE = 1 << F;

  function automatic logic [XW-1:0] take_feature(input logic signed [IN_W-1:0] raw,
                                                 input logic [IN_W-1:0] hi);
    logic [IN_W-1:0] c;
    logic [31:0]     w;
    if (raw < 0) begin
      c = '0;
    end else if ($unsigned(raw) > hi) begin
      c = hi;
    end else begin
      c = $unsigned(raw);
    end
    w = (32'(c) << SHL) >> SHR;
    return w[XW-1:0];
  endfunction

  logic [4:0]    vp;
  logic [XW-1:0] e_q, g_q, p_q;
  logic [MW-1:0] me [3];
  logic [MW-1:0] mg [3];
  logic [MW-1:0] mp [3];
  logic [2:0][MW-1:0] str_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q <= take_feature(entropy_level, ENT_HI);
      g_q <= take_feature(edge_strength, UNIT_HI);
      p_q <= take_feature(pressure_level, UNIT_HI);
    end
  end

  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(0),   .B(0),   .C(E15), .D(E30)) u_e0 (
    .clk(clk), .en(en), .x(e_q), .memb(me[0]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(E15), .B(E25), .C(E35), .D(E45)) u_e1 (
    .clk(clk), .en(en), .x(e_q), .memb(me[1]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(E30), .B(E45), .C(E60), .D(E60)) u_e2 (
    .clk(clk), .en(en), .x(e_q), .memb(me[2]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(0),   .B(0),   .C(G20), .D(G35)) u_g0 (
    .clk(clk), .en(en), .x(g_q), .memb(mg[0]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(G20), .B(G35), .C(G65), .D(G80)) u_g1 (
    .clk(clk), .en(en), .x(g_q), .memb(mg[1]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(G65), .B(G80), .C(ONE), .D(ONE)) u_g2 (
    .clk(clk), .en(en), .x(g_q), .memb(mg[2]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(0),   .B(0),   .C(P25), .D(P40)) u_p0 (
    .clk(clk), .en(en), .x(p_q), .memb(mp[0]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(P25), .B(P40), .C(P60), .D(P75)) u_p1 (
    .clk(clk), .en(en), .x(p_q), .memb(mp[1]));
  mfdi_member #(.FRAC_BITS(F), .XW(XW), .A(P60), .B(P75), .C(ONE), .D(ONE)) u_p2 (
    .clk(clk), .en(en), .x(p_q), .memb(mp[2]));

  always_comb begin
    logic [MW-1:0] w;
    int            c;
    str_next = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          w = me[i];
          if (mg[j] < w) w = mg[j];
          if (mp[k] < w) w = mp[k];
          c = int'(RULE_CLASS[i * 9 + j * 3 + k]);
          if (w > str_next[c]) str_next[c] = w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      strength <= str_next;
    end
  end

  assign out_valid = vp[4];
endmodule

// ----- rtl/core/mfdi_cell.sv -----
// One centroid stage: membership of one depth sample and accumulation of the previous one.
module mfdi_cell #(
  parameter int FRAC_BITS = 12,
  parameter int SAMPLE_COUNT = 100,
  parameter int IDX = 0,
  parameter int DW = 19,
  parameter int NW = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2:0][FRAC_BITS:0] str_in,
  input  logic [FRAC_BITS:0]      mu_in,
  input  logic [NW-1:0]           num_in,
  input  logic [DW-1:0]           den_in,
  output logic                    out_valid,
  output logic [2:0][FRAC_BITS:0] str_out,
  output logic [FRAC_BITS:0]      mu_out,
  output logic [NW-1:0]           num_out,
  output logic [DW-1:0]           den_out
);
  localparam int F   = FRAC_BITS;
  localparam int ONE = 1 << F;
  localparam int SM1 = SAMPLE_COUNT - 1;
  localparam int DS  = (IDX < SAMPLE_COUNT) ? ONE + (4 * IDX * ONE + SM1) / (2 * SM1) : 0;
  localparam int DP  = (IDX > 0) ? ONE + (4 * (IDX - 1) * ONE + SM1) / (2 * SM1) : 0;

  localparam int A0 = ONE;
  localparam int B0 = ONE;
  localparam int C0 = ((7 << F) + 2) / 5;
  localparam int D0 = ((9 << F) + 2) / 5;
  localparam int A1 = C0;
  localparam int B1 = D0;
  localparam int C1 = ((11 << F) + 2) / 5;
  localparam int D1 = ((13 << F) + 2) / 5;
  localparam int A2 = C1;
  localparam int B2 = D1;
  localparam int C2 = 3 << F;
  localparam int D2 = 3 << F;
  localparam int WR0 = (B0 > A0) ? B0 - A0 : 1;
  localparam int WF0 = (D0 > C0) ? D0 - C0 : 1;
  localparam int WR1 = (B1 > A1) ? B1 - A1 : 1;
  localparam int WF1 = (D1 > C1) ? D1 - C1 : 1;
  localparam int WR2 = (B2 > A2) ? B2 - A2 : 1;
  localparam int WF2 = (D2 > C2) ? D2 - C2 : 1;

  localparam int M0 = (IDX >= SAMPLE_COUNT) ? 0 :
                      (DS >= B0 && DS <= C0) ? ONE :
                      (DS <= A0 || DS >= D0) ? 0 :
                      (DS < B0) ? ((DS - A0) << F) / WR0 : ((D0 - DS) << F) / WF0;
  localparam int M1 = (IDX >= SAMPLE_COUNT) ? 0 :
                      (DS >= B1 && DS <= C1) ? ONE :
                      (DS <= A1 || DS >= D1) ? 0 :
                      (DS < B1) ? ((DS - A1) << F) / WR1 : ((D1 - DS) << F) / WF1;
  localparam int M2 = (IDX >= SAMPLE_COUNT) ? 0 :
                      (DS >= B2 && DS <= C2) ? ONE :
                      (DS <= A2 || DS >= D2) ? 0 :
                      (DS < B2) ? ((DS - A2) << F) / WR2 : ((D2 - DS) << F) / WF2;
  localparam int MK [3] = '{M0, M1, M2};

  logic [F:0] mu_next;

  always_comb begin
    logic [2*F+1:0] p;
    mu_next = '0;
    for (int k = 0; k < 3; k++) begin
      p = (2*F+2)'(MK[k]) * (2*F+2)'(str_in[k]);
      if (p[2*F:F] > mu_next) mu_next = p[2*F:F];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      str_out <= str_in;
      mu_out  <= mu_next;
      num_out <= num_in + NW'(DP) * NW'(mu_in);
      den_out <= den_in + DW'(mu_in);
    end
  end
endmodule

// ----- rtl/core/mfdi_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with round-half-up.
module mfdi_divider #(
  parameter int FRAC_BITS = 12,
  parameter int DW = 19,
  parameter int NW = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  output logic                 out_valid,
  output logic [FRAC_BITS+1:0] quotient,
  output logic                 zero_den
);
  localparam int QW = FRAC_BITS + 2;

  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dsr [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic          zd  [QW+1];
  logic [QW:0]   vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num + NW'(den >> 1);
      dsr[0] <= den;
      quo[0] <= '0;
      zd[0]  <= (den == '0);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int BIT = QW - 1 - j;
    logic [NW-1:0] sh;
    assign sh = NW'(dsr[j]) << BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        dsr[j+1] <= dsr[j];
        zd[j+1]  <= zd[j];
        if (rem[j] >= sh) begin
          rem[j+1] <= rem[j] - sh;
          quo[j+1] <= quo[j] | (QW'(1) << BIT);
        end else begin
          rem[j+1] <= rem[j];
          quo[j+1] <= quo[j];
        end
      end
    end
  end

  assign out_valid = vd[QW];
  assign quotient  = quo[QW];
  assign zero_den  = zd[QW];
endmodule

// ----- rtl/core/mamdani_fuzzy_depth_inference_top.sv -----
// Top level of the Mamdani fuzzy depth inference pipeline.
// Path from accepted feature word to depth word: the fuzzification stages with their input
// register, SAMPLE_COUNT + 1 centroid cells, the divider and the output register.
// Throughput: one word per cycle while the output is not stalled.
// Reset (rst, synchronous, active high) clears every valid bit; data registers are not reset.
module mamdani_fuzzy_depth_inference_top #(
  parameter int SAMPLE_COUNT = 100,
  parameter int FRAC_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  mfdi_feature_if.sink  feature,
  mfdi_depth_if.source  depth
);
  import mfdi_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int S   = SAMPLE_COUNT;
  // Denominator holds up to S * ONE, numerator up to 3 * ONE times that.
  localparam int DW  = F + $clog2(S + 1);
  localparam int NW  = DW + F + 2;
  localparam int QW  = F + 2;
  localparam int SHD = (F > IO_FRAC) ? F - IO_FRAC : 0;
  localparam int SHU = (F > IO_FRAC) ? 0 : IO_FRAC - F;
  localparam int RND = (F > IO_FRAC) ? 1 << (F - IO_FRAC - 1) : 0;

  // The whole pipeline moves as one: it advances whenever the output register
  // is empty or its word is being taken, so a stall freezes every stage.
  logic en;
  logic out_v;
  logic [DEPTH_W-1:0] out_depth;
  logic out_dflt;

  assign en            = !out_v || depth.ready;
  assign feature.ready = en;

  logic               fz_v;
  logic [2:0][F:0]    fz_str;

  mfdi_fuzzify #(.FRAC_BITS(F)) u_fuzzify (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (feature.valid),
    .entropy_level  (feature.entropy_level),
    .edge_strength  (feature.edge_strength),
    .pressure_level (feature.pressure_level),
    .out_valid      (fz_v),
    .strength       (fz_str)
  );

  // Centroid chain: cell i evaluates depth sample i and adds sample i-1 into
  // the running sums, so no stage holds two multiplications in series.
  logic            v_c   [S+2];
  logic [2:0][F:0] str_c [S+2];
  logic [F:0]      mu_c  [S+2];
  logic [NW-1:0]   num_c [S+2];
  logic [DW-1:0]   den_c [S+2];

  assign v_c[0]   = fz_v;
  assign str_c[0] = fz_str;
  assign mu_c[0]  = '0;
  assign num_c[0] = '0;
  assign den_c[0] = '0;

  for (genvar i = 0; i <= S; i++) begin : g_cell
    mfdi_cell #(
      .FRAC_BITS    (F),
      .SAMPLE_COUNT (S),
      .IDX          (i),
      .DW           (DW),
      .NW           (NW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_c[i]),
      .str_in    (str_c[i]),
      .mu_in     (mu_c[i]),
      .num_in    (num_c[i]),
      .den_in    (den_c[i]),
      .out_valid (v_c[i+1]),
      .str_out   (str_c[i+1]),
      .mu_out    (mu_c[i+1]),
      .num_out   (num_c[i+1]),
      .den_out   (den_c[i+1])
    );
  end

  logic          dv_v;
  logic [QW-1:0] dv_q;
  logic          dv_zero;

  mfdi_divider #(.FRAC_BITS(F), .DW(DW), .NW(NW)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_c[S+1]),
    .num       (num_c[S+1]),
    .den       (den_c[S+1]),
    .out_valid (dv_v),
    .quotient  (dv_q),
    .zero_den  (dv_zero)
  );

  // Conversion of the quotient to Q2.12, rounding half up when bits are dropped.
  logic [31:0] conv;
  assign conv = ((32'(dv_q) + 32'(RND)) >> SHD) << SHU;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dflt  <= dv_zero;
      out_depth <= dv_zero ? DEPTH_DEFAULT : conv[DEPTH_W-1:0];
    end
  end

  assign depth.valid        = out_v;
  assign depth.depth_value  = out_depth;
  assign depth.used_default = out_dflt;

  // When no rule fires, the word must carry the default depth.
  a_default_value: assert property (@(posedge clk) disable iff (rst)
    depth.valid && depth.used_default |-> depth.depth_value == DEPTH_DEFAULT)
    else $error("default flag raised without default depth");

  // A centroid of samples in [1,3] stays within [1,3].
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth.valid && !depth.used_default |->
      depth.depth_value >= DEPTH_MIN && depth.depth_value <= DEPTH_MAX)
    else $error("depth outside the sample range");

  // Reset empties the pipeline, so no word may appear right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !depth.valid)
    else $error("output word valid after reset");

endmodule
